// ===== rtl/core/lfp_pkg.sv =====
package lfp_pkg;

  localparam int unsigned HdrBytes = 6;
  localparam int unsigned IdBytes  = 2;
  localparam int unsigned HdrIdxW  = 3;

  localparam logic [HdrIdxW-1:0] HdrIdxFirst = '0;
  localparam logic [HdrIdxW-1:0] HdrIdxLenStart = HdrIdxW'(IdBytes);
  localparam logic [HdrIdxW-1:0] HdrIdxLast = HdrIdxW'(HdrBytes - 1);

  typedef enum logic {
    PhHeader = 1'b0,
    PhBody   = 1'b1
  } phase_e;

  typedef struct packed {
    logic       vld;
    logic [7:0] data;
  } in_item_t;

  typedef struct packed {
    logic [15:0] id;
    logic [31:0] len;
    logic [7:0]  body;
    logic        byte_valid;
    logic        last;
  } result_t;

endpackage

// ===== rtl/core/length_prefixed_frame_parser.sv =====
// Splits a received byte stream into messages, each a six-byte header
// (16-bit big-endian id, 32-bit big-endian body length) followed by the
// body. Each body byte comes out tagged with its message id and length;
// the final byte carries last_of_message, and a zero-length message gives
// one result with byte_valid low on its last header byte. Header bytes give
// no result. One byte is taken per clock cycle while out_stall_i is low: an
// input register feeds the parser, whose state update (a 32-bit down-count
// of remaining body bytes) loads a result register in the same cycle. Bytes
// go via the input and then the result register; out_stall_i holds the
// result register and stalls input once the input register is also full.
module length_prefixed_frame_parser (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  rx_byte_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [15:0] message_id_o,
  output logic [31:0] message_length_o,
  output logic [7:0]  body_byte_o,
  output logic        byte_valid_o,
  output logic        last_of_message_o
);

  lfp_pkg::in_item_t item;
  lfp_pkg::result_t  res;
  logic              take;

  lfp_in_stage u_in_stage (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .rx_byte_i  (rx_byte_i),
    .take_i     (take),
    .item_o     (item)
  );

  lfp_parse u_parse (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .item_i      (item),
    .take_o      (take),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .res_o       (res)
  );

  assign message_id_o      = res.id;
  assign message_length_o  = res.len;
  assign body_byte_o       = res.body;
  assign byte_valid_o      = res.byte_valid;
  assign last_of_message_o = res.last;

endmodule

// ===== rtl/core/lfp_in_stage.sv =====
module lfp_in_stage (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  logic [7:0]       rx_byte_i,
  input  logic             take_i,
  output lfp_pkg::in_item_t item_o
);

  logic       vld_q, vld_d;
  logic [7:0] data_q;
  logic       accept;

  assign in_stall_o = vld_q & ~take_i;
  assign accept     = in_valid_i & ~in_stall_o;

  always_comb begin
    vld_d = vld_q;
    if (accept) begin
      vld_d = 1'b1;
    end else if (take_i) begin
      vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      data_q <= rx_byte_i;
    end
  end

  assign item_o.vld  = vld_q;
  assign item_o.data = data_q;

endmodule

// ===== rtl/core/lfp_parse.sv =====
module lfp_parse (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  lfp_pkg::in_item_t item_i,
  output logic              take_o,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output lfp_pkg::result_t  res_o
);

  lfp_pkg::phase_e              phase_q, phase_d;
  logic [lfp_pkg::HdrIdxW-1:0]  idx_q, idx_d;
  logic [15:0]                  id_q, id_d;
  logic [31:0]                  len_q, len_d;
  logic [31:0]                  left_q, left_d;
  logic                         out_vld_q, out_vld_d;
  lfp_pkg::result_t             res_q, res_d;
  logic                         has_res;
  logic                         body_last;
  logic [15:0]                  id_base;
  logic [31:0]                  len_base;

  // Advance only when the result register is free or being emptied.
  assign take_o = item_i.vld & (~out_vld_q | ~out_stall_i);

  assign body_last = (left_q <= 32'd1);
  assign id_base   = (idx_q == lfp_pkg::HdrIdxFirst) ? 16'd0 : id_q;
  assign len_base  = (idx_q == lfp_pkg::HdrIdxFirst) ? 32'd0 : len_q;

  // Next state.
  always_comb begin
    phase_d = phase_q;
    idx_d   = idx_q;
    id_d    = id_q;
    len_d   = len_q;
    left_d  = left_q;
    if (take_o) begin
      case (phase_q)
        lfp_pkg::PhBody: begin
          if (body_last) begin
            phase_d = lfp_pkg::PhHeader;
            idx_d   = lfp_pkg::HdrIdxFirst;
            left_d  = 32'd0;
          end else begin
            left_d = left_q - 32'd1;
          end
        end
        lfp_pkg::PhHeader: begin
          if (idx_q < lfp_pkg::HdrIdxLenStart) begin
            id_d  = {id_base[7:0], item_i.data};
            len_d = len_base;
          end else begin
            id_d  = id_base;
            len_d = {len_base[23:0], item_i.data};
          end
          if (idx_q == lfp_pkg::HdrIdxLast) begin
            idx_d = lfp_pkg::HdrIdxFirst;
            if (len_d != 32'd0) begin
              phase_d = lfp_pkg::PhBody;
              left_d  = len_d;
            end
          end else begin
            idx_d = idx_q + lfp_pkg::HdrIdxW'(1);
          end
        end
        default: begin
          phase_d = lfp_pkg::PhHeader;
        end
      endcase
    end
  end

  // Result for the item being taken.
  always_comb begin
    has_res          = 1'b0;
    res_d.id         = id_d;
    res_d.len        = len_d;
    res_d.body       = item_i.data;
    res_d.byte_valid = 1'b1;
    res_d.last       = body_last;
    case (phase_q)
      lfp_pkg::PhBody: begin
        has_res = 1'b1;
      end
      lfp_pkg::PhHeader: begin
        // Empty message: mark done on the final header byte.
        has_res          = (idx_q == lfp_pkg::HdrIdxLast) && (len_d == 32'd0);
        res_d.body       = 8'd0;
        res_d.byte_valid = 1'b0;
        res_d.last       = 1'b1;
      end
      default: begin
        has_res = 1'b0;
      end
    endcase
  end

  always_comb begin
    out_vld_d = out_vld_q;
    if (take_o) begin
      out_vld_d = has_res;
    end else if (~out_stall_i) begin
      out_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= lfp_pkg::PhHeader;
      idx_q     <= lfp_pkg::HdrIdxFirst;
      id_q      <= 16'd0;
      len_q     <= 32'd0;
      left_q    <= 32'd0;
      out_vld_q <= 1'b0;
    end else begin
      phase_q   <= phase_d;
      idx_q     <= idx_d;
      id_q      <= id_d;
      len_q     <= len_d;
      left_q    <= left_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take_o && has_res) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o = out_vld_q;
  assign res_o       = res_q;

endmodule
